// ===== src/nibble_4b6b_pair_encoder_assert.svh =====
// assertion macros shared by the checker
`ifndef NIBBLE_4B6B_PAIR_ENCODER_ASSERT_SVH
`define NIBBLE_4B6B_PAIR_ENCODER_ASSERT_SVH

// same-cycle implication, ignored during reset
`define N4B6B_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored during reset
`define N4B6B_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset itself
`define N4B6B_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/n4b6b_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package n4b6b_pkg;

   localparam int MAX_OUTPUT_BYTES_DEFAULT = 4096;
   localparam int CAP_WIDTH = 13;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 13'd4080;
   localparam logic [CAP_WIDTH-1:0] BYTES_PER_WORD = 13'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_word_type;

   typedef struct packed {
      logic [23:0] code_word;
      logic        overflow;
      logic        last_word;
   } rsp_word_type;

   // balanced 6-bit symbol for one nibble
   function automatic logic [5:0] symbol_of(input logic [3:0] nibble);
      logic [5:0] sym;
      case (nibble)
         4'h0: sym = 6'h0d;
         4'h1: sym = 6'h0e;
         4'h2: sym = 6'h13;
         4'h3: sym = 6'h15;
         4'h4: sym = 6'h16;
         4'h5: sym = 6'h19;
         4'h6: sym = 6'h1a;
         4'h7: sym = 6'h1c;
         4'h8: sym = 6'h23;
         4'h9: sym = 6'h25;
         4'ha: sym = 6'h26;
         4'hb: sym = 6'h29;
         4'hc: sym = 6'h2a;
         4'hd: sym = 6'h2c;
         4'he: sym = 6'h32;
         4'hf: sym = 6'h34;
         default: sym = 6'h00;
      endcase
      return sym;
   endfunction

endpackage

`default_nettype wire

// ===== src/nibble_4b6b_pair_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pairs message bytes and encodes each nibble to a balanced 6-bit symbol,
// giving one 24-bit code word per byte pair (or per odd final byte, padded
// with zero bits). One byte is taken every cycle while req_stall is low: the
// lookup, capacity check and packing sit between the pairing state and the
// result register, which takes the word a byte completes unless one waits there.
// A skid register lets a byte be taken while a finished word waits. req_stall
// rises only while both the result register and the skid register are full.
// Output bytes are counted per message against csr_data, capped at
// MAX_OUTPUT_BYTES; the first word that would pass the limit returns a single
// overflow word and later bytes return nothing until end-of-message, which
// always returns a word with last_word set and clears the message state.
// The capacity register resets to 4080; the user must write it only while idle, as the block does not enforce this.

module nibble_4b6b_pair_encoder #(
   parameter int MAX_OUTPUT_BYTES = n4b6b_pkg::MAX_OUTPUT_BYTES_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  n4b6b_pkg::req_word_type     req_word,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output n4b6b_pkg::rsp_word_type           rsp_word,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [n4b6b_pkg::CAP_WIDTH-1:0]   csr_data
);

   localparam int CW = n4b6b_pkg::CAP_WIDTH;
   localparam logic [16:0] MaxBytes = 17'(MAX_OUTPUT_BYTES);

   logic [CW-1:0] capacity_ff;
   logic          half_ff, half_in;
   logic [7:0]    held_ff, held_in;
   logic [CW-1:0] count_ff, count_in;
   logic          err_ff, err_in;

   logic                    main_valid_ff, main_valid_in;
   n4b6b_pkg::rsp_word_type main_ff, main_in;
   logic                    skid_valid_ff, skid_valid_in;
   n4b6b_pkg::rsp_word_type skid_ff, skid_in;

   logic                    accept, pop, push;
   n4b6b_pkg::rsp_word_type result;
   logic [7:0]              first_byte, second_byte;
   logic [16:0]             cap_ext, cap_eff, count_next;
   logic                    over;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign pop       = main_valid_ff && !rsp_stall;
   assign rsp_valid = main_valid_ff;
   assign rsp_word  = main_ff;

   always_comb begin
      cap_ext    = {4'b0, capacity_ff};
      cap_eff    = (cap_ext > MaxBytes) ? MaxBytes : cap_ext;
      count_next = {4'b0, count_ff} + {4'b0, n4b6b_pkg::BYTES_PER_WORD};
      over       = count_next > cap_eff;
      first_byte  = half_ff ? held_ff : req_word.data_byte;
      second_byte = req_word.data_byte;

      half_in  = half_ff;
      held_in  = held_ff;
      count_in = count_ff;
      err_in   = err_ff;
      push     = 1'b0;
      result   = '0;

      if (accept) begin
         if (err_ff) begin
            if (req_word.end_of_message) begin
               push             = 1'b1;
               result.overflow  = 1'b1;
               result.last_word = 1'b1;
               half_in  = 1'b0;
               count_in = '0;
               err_in   = 1'b0;
            end
         end else if (!half_ff && !req_word.end_of_message) begin
            half_in = 1'b1;
            held_in = req_word.data_byte;
         end else begin
            push             = 1'b1;
            half_in          = 1'b0;
            result.last_word = req_word.end_of_message;
            if (over) begin
               result.overflow = 1'b1;
               err_in          = !req_word.end_of_message;
            end else begin
               result.code_word[23:18] = n4b6b_pkg::symbol_of(first_byte[7:4]);
               result.code_word[17:12] = n4b6b_pkg::symbol_of(first_byte[3:0]);
               // odd final byte leaves the second pair of slots zero
               if (half_ff) begin
                  result.code_word[11:6] = n4b6b_pkg::symbol_of(second_byte[7:4]);
                  result.code_word[5:0]  = n4b6b_pkg::symbol_of(second_byte[3:0]);
               end
               count_in = count_next[CW-1:0];
            end
            if (req_word.end_of_message) begin
               count_in = '0;
            end
         end
      end

      // result register with skid behind it
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         main_valid_in = 1'b0;
      end
      if (skid_valid_ff) begin
         if (pop) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= n4b6b_pkg::CAP_RESET;
         half_ff       <= 1'b0;
         count_ff      <= '0;
         err_ff        <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         half_ff       <= half_in;
         count_ff      <= count_in;
         err_ff        <= err_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ===== src/n4b6b_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "nibble_4b6b_pair_encoder_assert.svh"

module n4b6b_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire n4b6b_pkg::req_word_type req_word,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire n4b6b_pkg::rsp_word_type rsp_word
);

   // an overflow word never carries symbols
   `N4B6B_ASSERT_NOW(a_overflow_zero, rsp_valid && rsp_word.overflow,
      rsp_word.code_word == 24'd0, "overflow word with nonzero code")

   // a waiting word holds
   `N4B6B_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_word), "stalled word changed")

   // end-of-message into an empty output shows up next cycle as the closing word
   `N4B6B_ASSERT_NEXT(a_eom_closes,
      req_valid && !req_stall && req_word.end_of_message && !rsp_valid,
      rsp_valid && rsp_word.last_word, "end-of-message word missing")

   // reset leaves the output empty and the input open
   `N4B6B_ASSERT_NEXT_ANY(a_reset_empty, reset, !rsp_valid && !req_stall,
      "not empty after reset")

endmodule

bind nibble_4b6b_pair_encoder n4b6b_checker u_n4b6b_checker (.*);

`default_nettype wire

// ===== bench/nibble_4b6b_pair_encoder_tb.sv =====
`timescale 1ns / 1ps

module nibble_4b6b_pair_encoder_tb;

   localparam int CAP_FIELD_MAX = (1 << n4b6b_pkg::CAP_WIDTH) - 1;
   localparam int OUTPUT_LIMIT = n4b6b_pkg::MAX_OUTPUT_BYTES_DEFAULT;
   // symbol for nibble n sits at bits 6n+5..6n
   localparam logic [95:0] SYMBOLS = {
      6'h34, 6'h32, 6'h2c, 6'h2a, 6'h29, 6'h26, 6'h25, 6'h23,
      6'h1c, 6'h1a, 6'h19, 6'h16, 6'h15, 6'h13, 6'h0e, 6'h0d
   };

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   n4b6b_pkg::req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   n4b6b_pkg::rsp_word_type rsp_word;
   logic csr_valid;
   logic csr_ready;
   logic [n4b6b_pkg::CAP_WIDTH-1:0] csr_data;

   // encoder state as the bench sees it
   logic [n4b6b_pkg::CAP_WIDTH-1:0] capacity_reg;
   logic half_held;
   logic [7:0] held_byte;
   logic [n4b6b_pkg::CAP_WIDTH-1:0] bytes_out;
   logic overflowed;

   n4b6b_pkg::rsp_word_type pending_words[$];
   int mismatch_count;
   bit idle_en;
   int rsp_hold_cycles;
   int rsp_stall_left;
   bit step_produced;
   n4b6b_pkg::rsp_word_type step_word;
   n4b6b_pkg::rsp_word_type oldest_word;

   nibble_4b6b_pair_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("nibble_4b6b_pair_encoder test failed");
      $finish;
   end

   function automatic logic [5:0] nibble_symbol(input logic [3:0] nib);
      return SYMBOLS[int'(nib) * 6 +: 6];
   endfunction

   function automatic void clear_message();
      half_held = 1'b0;
      held_byte = '0;
      bytes_out = '0;
      overflowed = 1'b0;
   endfunction

   // one accepted byte in, at most one expected word out
   function automatic void encode_byte(input logic [7:0] data, input logic eom,
                                       output bit produced,
                                       output n4b6b_pkg::rsp_word_type word);
      logic [7:0] first;
      bit has_second;
      int cap;
      produced = 1'b0;
      word = '0;
      if (overflowed) begin
         if (eom) begin
            produced = 1'b1;
            word.overflow = 1'b1;
            word.last_word = 1'b1;
            clear_message();
         end
         return;
      end
      if (!half_held && !eom) begin
         held_byte = data;
         half_held = 1'b1;
         return;
      end
      first = half_held ? held_byte : data;
      has_second = half_held;
      cap = (int'(capacity_reg) > OUTPUT_LIMIT) ? OUTPUT_LIMIT : int'(capacity_reg);
      half_held = 1'b0;
      held_byte = '0;
      produced = 1'b1;
      word.last_word = eom;
      if (int'(bytes_out) + 3 > cap) begin
         word.overflow = 1'b1;
         if (eom)
            clear_message();
         else
            overflowed = 1'b1;
      end else begin
         // odd final byte: the two low slots stay all zero
         word.code_word = {nibble_symbol(first[7:4]), nibble_symbol(first[3:0]),
                           has_second ? nibble_symbol(data[7:4]) : 6'h00,
                           has_second ? nibble_symbol(data[3:0]) : 6'h00};
         if (eom)
            clear_message();
         else
            bytes_out = bytes_out + n4b6b_pkg::BYTES_PER_WORD;
      end
   endfunction

   function automatic void report_mismatch(input string what,
                                           input n4b6b_pkg::rsp_word_type exp_w,
                                           input n4b6b_pkg::rsp_word_type act_w);
      if (mismatch_count < 10)
         $display("%0t: %s: expected code_word %h overflow %b last_word %b, got %h %b %b",
                  $time, what, exp_w.code_word, exp_w.overflow, exp_w.last_word,
                  act_w.code_word, act_w.overflow, act_w.last_word);
      mismatch_count++;
   endfunction

   // byte acceptance is handled before word checking in the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            encode_byte(req_word.data_byte, req_word.end_of_message, step_produced, step_word);
            if (step_produced)
               pending_words.push_back(step_word);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               report_mismatch("word with nothing pending", '0, rsp_word);
            end else begin
               oldest_word = pending_words.pop_front();
               if (rsp_word.code_word !== oldest_word.code_word)
                  report_mismatch("code_word", oldest_word, rsp_word);
               else if (rsp_word.overflow !== oldest_word.overflow)
                  report_mismatch("overflow", oldest_word, rsp_word);
               else if (rsp_word.last_word !== oldest_word.last_word)
                  report_mismatch("last_word", oldest_word, rsp_word);
            end
         end
      end
   end

   // receiver: random stall bursts, plus a long hold when asked
   initial begin
      rsp_stall = 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else if (rsp_stall_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_stall_left--;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            rsp_stall_left = int'($urandom_range(0, 8));
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic eom);
      int gap;
      gap = (idle_en && $urandom_range(0, 4) == 0) ? int'($urandom_range(1, 9)) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{data_byte: data, end_of_message: eom};
      do @(posedge clock); while (req_stall);
   endtask

   // a held byte gives no word, so the wait goes on after the pending queue empties
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value[n4b6b_pkg::CAP_WIDTH-1:0];
      do @(posedge clock); while (!csr_ready);
      capacity_reg = value[n4b6b_pkg::CAP_WIDTH-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_messages(input int item_target, input bit allow_idle);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < item_target) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 7))
               0: write_capacity(0);
               1: write_capacity(3);
               2: write_capacity(OUTPUT_LIMIT);
               3: write_capacity(CAP_FIELD_MAX);
               7: write_capacity(int'($urandom_range(0, CAP_FIELD_MAX)));
               default: write_capacity(int'($urandom_range(0, 60)));
            endcase
            idle_en = allow_idle && ($urandom_range(0, 3) != 0);
         end
         pick = int'($urandom_range(0, 19));
         if (pick < 13)
            len = int'($urandom_range(1, 12));
         else if (pick < 19)
            len = int'($urandom_range(13, 40));
         else
            len = int'($urandom_range(41, 120));
         for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
         sent += len;
      end
   endtask

   task automatic test_directed_codes();
      // every nibble in order, last word closes the message
      send_byte(8'h01, 1'b0);
      send_byte(8'h23, 1'b0);
      send_byte(8'h45, 1'b0);
      send_byte(8'h67, 1'b0);
      send_byte(8'h89, 1'b0);
      send_byte(8'hab, 1'b0);
      send_byte(8'hcd, 1'b0);
      send_byte(8'hef, 1'b1);
      // extremes, then an odd final byte padded with zero bits
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
      // message of one byte
      send_byte(8'h5a, 1'b1);
      // room for one word only: overflow, silence, then a closing overflow
      write_capacity(3);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h3c, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b1);
      // no room at all
      write_capacity(0);
      send_byte(8'h77, 1'b1);
      send_byte(8'h88, 1'b0);
      send_byte(8'h99, 1'b0);
      send_byte(8'hee, 1'b1);
      write_capacity(int'(n4b6b_pkg::CAP_RESET));
   endtask

   task automatic test_capacity_change();
      // five words plus a held byte, then shrink capacity below the count
      for (int i = 0; i < 11; i++)
         send_byte(8'($urandom_range(0, 255)), 1'b0);
      write_capacity(9);
      send_byte(8'h42, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h10, 1'b1);
      write_capacity(int'(n4b6b_pkg::CAP_RESET));
   endtask

   task automatic test_backpressure();
      idle_en = 1'b0;
      rsp_hold_cycles = 80;
      for (int i = 0; i < 40; i++)
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      wait_for_results();
      idle_en = 1'b1;
   endtask

   task automatic test_random_traffic();
      send_random_messages(1400, 1'b1);
   endtask

   task automatic test_steady_stream();
      idle_en = 1'b0;
      send_random_messages(400, 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      idle_en = 1'b1;
      rsp_hold_cycles = 0;
      mismatch_count = 0;
      capacity_reg = n4b6b_pkg::CAP_RESET;
      clear_message();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_codes();
      test_capacity_change();
      test_backpressure();
      test_random_traffic();
      test_steady_stream();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("nibble_4b6b_pair_encoder test passed");
      else
         $display("nibble_4b6b_pair_encoder test failed");
      $finish;
   end

endmodule
